[design/idllm_pkg.sv]
// Shared types, constants and helpers of the linked-list queue manager.
`default_nettype none
package idllm_pkg;

   localparam int NUM_ENTRIES = 1024;
   localparam int NUM_LISTS   = 8;
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES);
   localparam int LINK_W      = ENTRY_W + 1;
   localparam int LIST_W      = $clog2(NUM_LISTS);
   localparam int SEL_W       = 3;
   localparam int CNT_W       = 11;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LINK_W-1:0] LINK_NULL    = '1;
   localparam logic [CNT_W-1:0]  IN_USE_RESET = CNT_W'(1024);

   // register index decode (paddr[2])
   localparam logic REG_IN_USE = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_PREPEND = 2'd0,
      OP_UNLINK  = 2'd1,
      OP_APPEND  = 2'd2,
      OP_POP     = 2'd3
   } op_type;

   // one read port shared by both link arrays, one write port each
   typedef struct packed {
      logic                rd_en;
      logic [ENTRY_W-1:0]  rd_addr;
      logic                next_we;
      logic [ENTRY_W-1:0]  next_waddr;
      logic [LINK_W-1:0]   next_wdata;
      logic                prev_we;
      logic [ENTRY_W-1:0]  prev_waddr;
      logic [LINK_W-1:0]   prev_wdata;
   } link_cmd_type;

   function automatic logic in_table(input logic [LINK_W-1:0] link);
      return link < LINK_W'(NUM_ENTRIES);
   endfunction

endpackage
`default_nettype wire

[design/idllm_link_mem.sv]
// Next and previous link memories, one registered read port, one write port each.
`default_nettype none
module idllm_link_mem (
   input  wire logic                              clock,
   input  wire idllm_pkg::link_cmd_type           cmd,
   output logic [idllm_pkg::LINK_W-1:0]           next_rdata,
   output logic [idllm_pkg::LINK_W-1:0]           prev_rdata
);

   logic [idllm_pkg::LINK_W-1:0] next_mem [idllm_pkg::NUM_ENTRIES];
   logic [idllm_pkg::LINK_W-1:0] prev_mem [idllm_pkg::NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (cmd.next_we) begin
         next_mem[cmd.next_waddr] <= cmd.next_wdata;
      end
      if (cmd.prev_we) begin
         prev_mem[cmd.prev_waddr] <= cmd.prev_wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         next_rdata <= next_mem[cmd.rd_addr];
         prev_rdata <= prev_mem[cmd.rd_addr];
      end
   end

endmodule
`default_nettype wire

[design/indexed_doubly_linked_list_manager.sv]
// Top level: list head/tail registers, request sequencer, CSR port.
//
//  port group   direction  handshake            contents
//  req_*        in         req_valid/req_stall  type, list select, entry index
//  rsp_*        out        rsp_valid/rsp_stall  popped index, status
//  csr_*        in/out     APB psel/penable     entries_in_use at 0x0
//
// Each request runs through accept, link memory read (plus independent
// writes), then the dependent write-back with head/tail update and result load.
// The single read port of the link memories sets this order of steps.
// Reset (synchronous) empties all lists and sets entries_in_use to 1024;
// link memories are not cleared.
// A stalled result holds the write-back step; a new request is taken once the
// previous one has written back, even while its result waits.
`default_nettype none
module indexed_doubly_linked_list_manager (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_type,
   input  wire logic [idllm_pkg::SEL_W-1:0]          req_list_select,
   input  wire logic [idllm_pkg::ENTRY_W-1:0]        req_entry_index,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [idllm_pkg::ENTRY_W-1:0]             rsp_popped_index,
   output logic [idllm_pkg::STATUS_W-1:0]            rsp_status,

   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [idllm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [idllm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [idllm_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                      csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WRITE
   } state_type;

   state_type                          state_ff;
   idllm_pkg::op_type                  op_ff;
   logic [idllm_pkg::LIST_W-1:0]       ls_ff;
   logic [idllm_pkg::ENTRY_W-1:0]      e_ff;
   logic                               rsp_valid_ff;
   logic [idllm_pkg::ENTRY_W-1:0]      rsp_popped_ff;
   logic [idllm_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [idllm_pkg::CNT_W-1:0]        in_use_ff;

   logic [idllm_pkg::LINK_W-1:0]       head_ff [idllm_pkg::NUM_LISTS];
   logic [idllm_pkg::LINK_W-1:0]       tail_ff [idllm_pkg::NUM_LISTS];

   idllm_pkg::link_cmd_type            cmd;
   logic [idllm_pkg::LINK_W-1:0]       next_rdata;
   logic [idllm_pkg::LINK_W-1:0]       prev_rdata;

   logic [idllm_pkg::LINK_W-1:0]       h;
   logic [idllm_pkg::LINK_W-1:0]       t;
   logic [idllm_pkg::LINK_W-1:0]       e_link;
   logic [idllm_pkg::LINK_W-1:0]       pop_next;
   logic                               h_null;
   logic                               t_null;
   logic                               req_ok;
   logic [idllm_pkg::STATUS_W-1:0]     status;
   logic                               out_free;
   logic                               commit;
   logic                               head_we;
   logic                               tail_we;
   logic [idllm_pkg::LINK_W-1:0]       head_in;
   logic [idllm_pkg::LINK_W-1:0]       tail_in;
   logic                               csr_write;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == idllm_pkg::REG_IN_USE)
                       ? idllm_pkg::CSR_DATA_W'(in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= idllm_pkg::IN_USE_RESET;
      end else if (csr_write && csr_paddr[2] == idllm_pkg::REG_IN_USE) begin
         in_use_ff <= csr_pwdata[idllm_pkg::CNT_W-1:0];
      end
   end

   // ---------------- request decode ----------------
   assign h        = head_ff[ls_ff];
   assign t        = tail_ff[ls_ff];
   assign h_null   = (h == idllm_pkg::LINK_NULL);
   assign t_null   = (t == idllm_pkg::LINK_NULL);
   assign e_link   = {1'b0, e_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == S_WRITE) && out_free;

   always_comb begin
      if (op_ff == idllm_pkg::OP_POP) begin
         status = h_null ? idllm_pkg::STATUS_EMPTY : idllm_pkg::STATUS_OK;
      end else if (idllm_pkg::CNT_W'(e_link) >= in_use_ff) begin
         status = idllm_pkg::STATUS_RANGE;
      end else begin
         status = idllm_pkg::STATUS_OK;
      end
   end
   assign req_ok = (status == idllm_pkg::STATUS_OK);

   // pop: next link of the old head, null if the head lies outside the table
   assign pop_next = idllm_pkg::in_table(h) ? next_rdata : idllm_pkg::LINK_NULL;

   // ---------------- link memory commands and head/tail updates ----------------
   always_comb begin
      cmd     = '0;
      head_we = 1'b0;
      tail_we = 1'b0;
      head_in = idllm_pkg::LINK_NULL;
      tail_in = idllm_pkg::LINK_NULL;

      if (state_ff == S_READ && req_ok) begin
         case (op_ff)
            idllm_pkg::OP_PREPEND: begin
               cmd.prev_we    = idllm_pkg::in_table(h);
               cmd.prev_waddr = h[idllm_pkg::ENTRY_W-1:0];
               cmd.prev_wdata = e_link;
               cmd.next_we    = 1'b1;
               cmd.next_waddr = e_ff;
               cmd.next_wdata = h;
            end
            idllm_pkg::OP_UNLINK: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = e_ff;
            end
            idllm_pkg::OP_APPEND: begin
               cmd.next_we    = 1'b1;
               cmd.next_waddr = e_ff;
               cmd.next_wdata = idllm_pkg::LINK_NULL;
               cmd.prev_we    = 1'b1;
               cmd.prev_waddr = e_ff;
               cmd.prev_wdata = (h_null && t_null) ? idllm_pkg::LINK_NULL : t;
            end
            idllm_pkg::OP_POP: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = h[idllm_pkg::ENTRY_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (commit && req_ok) begin
         case (op_ff)
            idllm_pkg::OP_PREPEND: begin
               // after prev[h] = e, so a self-insert ends with a null prev
               cmd.prev_we    = 1'b1;
               cmd.prev_waddr = e_ff;
               cmd.prev_wdata = idllm_pkg::LINK_NULL;
               head_we        = 1'b1;
               head_in        = e_link;
               tail_we        = h_null;
               tail_in        = e_link;
            end
            idllm_pkg::OP_UNLINK: begin
               // prev_rdata = p, next_rdata = n of the unlinked entry
               if (prev_rdata == idllm_pkg::LINK_NULL) begin
                  head_we = 1'b1;
                  head_in = next_rdata;
               end else begin
                  cmd.next_we    = idllm_pkg::in_table(prev_rdata);
                  cmd.next_waddr = prev_rdata[idllm_pkg::ENTRY_W-1:0];
                  cmd.next_wdata = next_rdata;
               end
               if (next_rdata == idllm_pkg::LINK_NULL) begin
                  tail_we = 1'b1;
                  tail_in = prev_rdata;
               end else begin
                  cmd.prev_we    = idllm_pkg::in_table(next_rdata);
                  cmd.prev_waddr = next_rdata[idllm_pkg::ENTRY_W-1:0];
                  cmd.prev_wdata = prev_rdata;
               end
            end
            idllm_pkg::OP_APPEND: begin
               if (h_null && t_null) begin
                  head_we = 1'b1;
                  head_in = e_link;
               end else begin
                  cmd.next_we    = idllm_pkg::in_table(t);
                  cmd.next_waddr = t[idllm_pkg::ENTRY_W-1:0];
                  cmd.next_wdata = e_link;
               end
               tail_we = 1'b1;
               tail_in = e_link;
            end
            idllm_pkg::OP_POP: begin
               head_we = 1'b1;
               if (h == t) begin
                  head_in = idllm_pkg::LINK_NULL;
                  tail_we = 1'b1;
                  tail_in = idllm_pkg::LINK_NULL;
               end else begin
                  head_in        = pop_next;
                  cmd.prev_we    = idllm_pkg::in_table(pop_next);
                  cmd.prev_waddr = pop_next[idllm_pkg::ENTRY_W-1:0];
                  cmd.prev_wdata = idllm_pkg::LINK_NULL;
               end
            end
            default: begin
            end
         endcase
      end
   end

   idllm_link_mem u_link_mem (
      .clock      (clock),
      .cmd        (cmd),
      .next_rdata (next_rdata),
      .prev_rdata (prev_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < idllm_pkg::NUM_LISTS; i++) begin
            head_ff[i] <= idllm_pkg::LINK_NULL;
            tail_ff[i] <= idllm_pkg::LINK_NULL;
         end
      end else begin
         if (head_we) begin
            head_ff[ls_ff] <= head_in;
         end
         if (tail_we) begin
            tail_ff[ls_ff] <= tail_in;
         end
      end
   end

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != S_IDLE);

   // state and result word; a new result may replace one taken at the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status;
            rsp_popped_ff <= (req_ok && op_ff == idllm_pkg::OP_POP)
                             ? h[idllm_pkg::ENTRY_W-1:0] : '0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // request word payload
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= idllm_pkg::op_type'(req_type);
         ls_ff <= idllm_pkg::LIST_W'(req_list_select % idllm_pkg::NUM_LISTS);
         e_ff  <= req_entry_index;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_index = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;

   // ---------------- assertions ----------------
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_WRITE)
      else $error("result word loaded outside write-back");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != idllm_pkg::STATUS_OK |-> rsp_popped_ff == '0)
      else $error("failed request returned a popped index");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == idllm_pkg::STATUS_OK ||
                        rsp_status_ff == idllm_pkg::STATUS_RANGE ||
                        rsp_status_ff == idllm_pkg::STATUS_EMPTY))
      else $error("bad status code");

   a_mem_access: assert property (@(posedge clock) disable iff (reset)
      (cmd.next_we || cmd.prev_we || cmd.rd_en) |-> state_ff != S_IDLE)
      else $error("link memory accessed while idle");

   a_list_update: assert property (@(posedge clock) disable iff (reset)
      (head_we || tail_we) |-> commit && req_ok)
      else $error("head or tail changed outside a successful write-back");

endmodule
`default_nettype wire
